// ----- sv/bsc_pkg.sv -----
`default_nettype none
package bsc_pkg;

   localparam int unsigned RawWidth   = 24;
   localparam int unsigned ValueWidth = 32;
   localparam int unsigned CsrIdxW    = 8;
   localparam int unsigned CsrDataW   = 64;
   localparam int unsigned DivCntW    = 5;

   localparam logic [CsrIdxW-1:0] CSR_COEFF_A = 8'd0;
   localparam logic [CsrIdxW-1:0] CSR_COEFF_B = 8'd1;
   localparam logic [CsrIdxW-1:0] CSR_COEFF_C = 8'd2;
   localparam logic [CsrIdxW-1:0] CSR_OSS     = 8'd3;

   localparam logic OP_TEMP  = 1'b0;
   localparam logic OP_PRESS = 1'b1;

   localparam logic [31:0] C_B6_OFS   = 32'd4000;
   localparam logic [31:0] C_B4_OFS   = 32'd32768;
   localparam logic [31:0] C_B7_SCALE = 32'd50000;
   localparam logic [31:0] C_P_SQ     = 32'd3038;
   localparam logic [31:0] C_P_LIN    = 32'hFFFF_E343;
   localparam logic [31:0] C_P_OFS    = 32'd3791;

   typedef enum logic [4:0] {
      ST_IDLE, ST_T_MUL, ST_T_X1, ST_T_DEN, ST_DIV, ST_T_FIN, ST_T_VAL, ST_ZERO,
      ST_P_B6, ST_P_SQ, ST_P_SQS, ST_P_X2A, ST_P_X1A, ST_P_B3, ST_P_X3, ST_P_B4M,
      ST_P_B4, ST_P_B7, ST_P_Q, ST_P_H, ST_P_M1, ST_P_M2, ST_P_FIN, ST_OUT
   } state_type;

   typedef struct packed {
      state_type step;
      logic      load_in;
      logic      load_out;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic div_zero;
      logic div_done;
      logic out_free;
   } stat_type;

   function automatic logic [31:0] sx16(input logic [15:0] v);
      return {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] s);
      return 32'($signed(v) >>> s);
   endfunction

endpackage
`default_nettype wire

// ----- sv/bsc_ctrl.sv -----
`default_nettype none
module bsc_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_tvalid,
   output logic                 req_tready,
   input  wire bsc_pkg::stat_type stat,
   output bsc_pkg::cmd_type     cmd
);

   bsc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bsc_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = bsc_pkg::ST_IDLE;
            end
         end
         bsc_pkg::ST_T_MUL:  state_in = bsc_pkg::ST_T_X1;
         bsc_pkg::ST_T_X1:   state_in = bsc_pkg::ST_T_DEN;
         bsc_pkg::ST_T_DEN:  state_in = stat.div_zero ? bsc_pkg::ST_ZERO : bsc_pkg::ST_DIV;
         bsc_pkg::ST_DIV: begin
            if (stat.div_done) begin
               state_in = (stat.op == bsc_pkg::OP_PRESS) ? bsc_pkg::ST_P_Q : bsc_pkg::ST_T_FIN;
            end
         end
         bsc_pkg::ST_T_FIN:  state_in = bsc_pkg::ST_T_VAL;
         bsc_pkg::ST_T_VAL:  state_in = bsc_pkg::ST_OUT;
         bsc_pkg::ST_ZERO:   state_in = bsc_pkg::ST_OUT;
         bsc_pkg::ST_P_B6:   state_in = bsc_pkg::ST_P_SQ;
         bsc_pkg::ST_P_SQ:   state_in = bsc_pkg::ST_P_SQS;
         bsc_pkg::ST_P_SQS:  state_in = bsc_pkg::ST_P_X2A;
         bsc_pkg::ST_P_X2A:  state_in = bsc_pkg::ST_P_X1A;
         bsc_pkg::ST_P_X1A:  state_in = bsc_pkg::ST_P_B3;
         bsc_pkg::ST_P_B3:   state_in = bsc_pkg::ST_P_X3;
         bsc_pkg::ST_P_X3:   state_in = bsc_pkg::ST_P_B4M;
         bsc_pkg::ST_P_B4M:  state_in = bsc_pkg::ST_P_B4;
         bsc_pkg::ST_P_B4:   state_in = bsc_pkg::ST_P_B7;
         bsc_pkg::ST_P_B7:   state_in = stat.div_zero ? bsc_pkg::ST_ZERO : bsc_pkg::ST_DIV;
         bsc_pkg::ST_P_Q:    state_in = bsc_pkg::ST_P_H;
         bsc_pkg::ST_P_H:    state_in = bsc_pkg::ST_P_M1;
         bsc_pkg::ST_P_M1:   state_in = bsc_pkg::ST_P_M2;
         bsc_pkg::ST_P_M2:   state_in = bsc_pkg::ST_P_FIN;
         bsc_pkg::ST_P_FIN:  state_in = bsc_pkg::ST_OUT;
         bsc_pkg::ST_OUT: begin
            if (stat.out_free) begin
               state_in = bsc_pkg::ST_IDLE;
            end
         end
         default:            state_in = bsc_pkg::ST_IDLE;
      endcase
      if (state_ff == bsc_pkg::ST_IDLE && req_tvalid) begin
         state_in = bsc_pkg::ST_P_B6;
         if (stat.op == bsc_pkg::OP_TEMP) begin
            state_in = bsc_pkg::ST_T_MUL;
         end
      end
   end

   always_comb begin
      req_tready   = (state_ff == bsc_pkg::ST_IDLE);
      cmd.step     = state_ff;
      cmd.load_in  = (state_ff == bsc_pkg::ST_IDLE) && req_tvalid;
      cmd.load_out = (state_ff == bsc_pkg::ST_OUT) && stat.out_free;
   end

endmodule
`default_nettype wire

// ----- sv/bsc_datapath.sv -----
`default_nettype none
module bsc_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [bsc_pkg::RawWidth-1:0]      req_tdata,
   input  wire logic                              req_tuser,
   input  wire logic                              csr_valid,
   input  wire logic [bsc_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [bsc_pkg::CsrDataW-1:0]      csr_data,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bsc_pkg::ValueWidth-1:0]         rsp_tdata,
   output logic [1:0]                             rsp_tuser,
   input  wire bsc_pkg::cmd_type                  cmd,
   output bsc_pkg::stat_type                      stat
);

   logic [63:0] cwa_ff, cwb_ff;
   logic [47:0] cwc_ff;
   logic [1:0]  oss_ff;
   logic [31:0] tt_ff, tt_in;
   logic [23:0] raw_ff;
   logic        op_ff;
   logic [31:0] p_ff, p_in, x1_ff, x1_in, b6_ff, b6_in, sq_ff, sq_in;
   logic [31:0] b3_ff, b3_in, b4_ff, b4_in, up_ff, up_in, pv_ff, pv_in;
   logic [31:0] n_ff, n_in, rem_ff, rem_in, dv_ff, dv_in;
   logic        neg_ff, neg_in, dbl_ff, dbl_in;
   logic [bsc_pkg::DivCntW-1:0] cnt_ff, cnt_in;
   logic [31:0] val_ff, val_in;
   logic        st_ff, st_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic [31:0] ma, mb, prod, den, num, q, b3t;
   logic [32:0] trial;

   assign ac1 = bsc_pkg::sx16(cwa_ff[63:48]);
   assign ac2 = bsc_pkg::sx16(cwa_ff[47:32]);
   assign ac3 = bsc_pkg::sx16(cwa_ff[31:16]);
   assign ac4 = {16'd0, cwa_ff[15:0]};
   assign ac5 = {16'd0, cwb_ff[63:48]};
   assign ac6 = {16'd0, cwb_ff[47:32]};
   assign b1  = bsc_pkg::sx16(cwb_ff[31:16]);
   assign b2  = bsc_pkg::sx16(cwb_ff[15:0]);
   assign mc  = bsc_pkg::sx16(cwc_ff[31:16]);
   assign md  = bsc_pkg::sx16(cwc_ff[15:0]);

   assign prod  = ma * mb;
   assign den   = x1_ff + md;
   assign num   = mc << 11;
   assign trial = {rem_ff, n_ff[31]} - {1'b0, dv_ff};
   assign q     = neg_ff ? (32'd0 - n_ff) : n_ff;
   assign b3t   = (((ac1 << 2) + x1_ff) << oss_ff) + 32'd2;

   always_comb begin
      ma = 32'd0;
      mb = 32'd0;
      unique case (cmd.step)
         bsc_pkg::ST_T_MUL: begin
            ma = {16'd0, raw_ff[15:0]} - ac6;
            mb = ac5;
         end
         bsc_pkg::ST_P_SQ:  begin ma = b6_ff; mb = b6_ff; end
         bsc_pkg::ST_P_SQS: begin ma = ac2;   mb = b6_ff; end
         bsc_pkg::ST_P_X2A: begin ma = b2;    mb = sq_ff; end
         bsc_pkg::ST_P_X1A: begin ma = ac3;   mb = b6_ff; end
         bsc_pkg::ST_P_B3:  begin ma = b1;    mb = sq_ff; end
         bsc_pkg::ST_P_B4M: begin ma = ac4;   mb = x1_ff + bsc_pkg::C_B4_OFS; end
         bsc_pkg::ST_P_B4: begin
            ma = up_ff - b3_ff;
            mb = bsc_pkg::C_B7_SCALE >> oss_ff;
         end
         bsc_pkg::ST_P_H: begin
            ma = bsc_pkg::asr(pv_ff, 5'd8);
            mb = bsc_pkg::asr(pv_ff, 5'd8);
         end
         bsc_pkg::ST_P_M1:  begin ma = p_ff;  mb = bsc_pkg::C_P_SQ; end
         bsc_pkg::ST_P_M2:  begin ma = bsc_pkg::C_P_LIN; mb = pv_ff; end
         default: begin
            ma = 32'd0;
            mb = 32'd0;
         end
      endcase
   end

   always_comb begin
      tt_in  = tt_ff;  p_in   = prod;   x1_in  = x1_ff;  b6_in  = b6_ff;
      sq_in  = sq_ff;  b3_in  = b3_ff;  b4_in  = b4_ff;  up_in  = up_ff;
      pv_in  = pv_ff;  n_in   = n_ff;   rem_in = rem_ff; dv_in  = dv_ff;
      neg_in = neg_ff; dbl_in = dbl_ff; cnt_in = cnt_ff; val_in = val_ff;
      st_in  = st_ff;
      unique case (cmd.step)
         bsc_pkg::ST_T_X1:  x1_in = bsc_pkg::asr(p_ff, 5'd15);
         bsc_pkg::ST_T_DEN: begin
            n_in   = num[31] ? (32'd0 - num) : num;
            dv_in  = den[31] ? (32'd0 - den) : den;
            neg_in = num[31] ^ den[31];
            rem_in = 32'd0;
            cnt_in = '0;
         end
         bsc_pkg::ST_DIV: begin
            if (!trial[32]) begin
               rem_in = trial[31:0];
               n_in   = {n_ff[30:0], 1'b1};
            end else begin
               rem_in = {rem_ff[30:0], n_ff[31]};
               n_in   = {n_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
         end
         bsc_pkg::ST_T_FIN: tt_in = x1_ff + q;
         bsc_pkg::ST_T_VAL: begin
            val_in = bsc_pkg::asr(tt_ff + 32'd8, 5'd4);
            st_in  = 1'b0;
         end
         bsc_pkg::ST_ZERO: begin
            val_in = 32'd0;
            st_in  = 1'b1;
         end
         bsc_pkg::ST_P_B6: begin
            b6_in = tt_ff - bsc_pkg::C_B6_OFS;
            up_in = {8'd0, raw_ff} >> (4'd8 - {2'd0, oss_ff});
         end
         bsc_pkg::ST_P_SQS: sq_in = bsc_pkg::asr(p_ff, 5'd12);
         bsc_pkg::ST_P_X2A: x1_in = bsc_pkg::asr(p_ff, 5'd11);
         bsc_pkg::ST_P_X1A: x1_in = x1_ff + bsc_pkg::asr(p_ff, 5'd11);
         bsc_pkg::ST_P_B3: begin
            b3_in = bsc_pkg::asr(b3t, 5'd2);
            x1_in = bsc_pkg::asr(p_ff, 5'd13);
         end
         bsc_pkg::ST_P_X3:
            x1_in = bsc_pkg::asr(bsc_pkg::asr(p_ff, 5'd16) + x1_ff + 32'd2, 5'd2);
         bsc_pkg::ST_P_B4:  b4_in = p_ff >> 15;
         bsc_pkg::ST_P_B7: begin
            n_in   = p_ff[31] ? p_ff : (p_ff << 1);
            dbl_in = p_ff[31];
            dv_in  = b4_ff;
            neg_in = 1'b0;
            rem_in = 32'd0;
            cnt_in = '0;
         end
         bsc_pkg::ST_P_Q:   pv_in = dbl_ff ? (n_ff << 1) : n_ff;
         bsc_pkg::ST_P_M2:  x1_in = bsc_pkg::asr(p_ff, 5'd16);
         bsc_pkg::ST_P_FIN: begin
            val_in = pv_ff + bsc_pkg::asr(x1_ff + bsc_pkg::asr(p_ff, 5'd16)
                                          + bsc_pkg::C_P_OFS, 5'd4);
            st_in  = 1'b0;
         end
         default: begin
            p_in = prod;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cwa_ff       <= '0;
         cwb_ff       <= '0;
         cwc_ff       <= '0;
         oss_ff       <= '0;
         tt_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tt_ff        <= tt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) begin
            unique case (csr_index)
               bsc_pkg::CSR_COEFF_A: cwa_ff <= csr_data;
               bsc_pkg::CSR_COEFF_B: cwb_ff <= csr_data;
               bsc_pkg::CSR_COEFF_C: cwc_ff <= csr_data[47:0];
               bsc_pkg::CSR_OSS:     oss_ff <= csr_data[1:0];
               default: begin
                  oss_ff <= oss_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         raw_ff <= req_tdata;
         op_ff  <= req_tuser;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= val_ff;
         rsp_user_ff <= {st_ff, op_ff};
      end
      p_ff   <= p_in;   x1_ff  <= x1_in;  b6_ff  <= b6_in;  sq_ff  <= sq_in;
      b3_ff  <= b3_in;  b4_ff  <= b4_in;  up_ff  <= up_in;  pv_ff  <= pv_in;
      n_ff   <= n_in;   rem_ff <= rem_in; dv_ff  <= dv_in;  neg_ff <= neg_in;
      dbl_ff <= dbl_in; cnt_ff <= cnt_in; val_ff <= val_in; st_ff  <= st_in;
   end

   always_comb begin
      stat.op       = cmd.load_in ? req_tuser : op_ff;
      stat.div_zero = (cmd.step == bsc_pkg::ST_T_DEN) ? (den == 32'd0) : (b4_ff == 32'd0);
      stat.div_done = (cnt_ff == {bsc_pkg::DivCntW{1'b1}});
      stat.out_free = !rsp_valid_ff || rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
`default_nettype wire

// ----- sv/barometric_sensor_compensation.sv -----
// Temperature and pressure compensation for a barometric sensor. Write the three
// calibration words and the oversampling setting on the csr_ port while idle, then send
// raw readings (tuser 0 = temperature, 1 = pressure). Each item runs from acceptance to
// result through the sequencer's single shared 32x32 multiplier and the 32-step
// restoring divider, which is skipped when the divisor is zero; one item is in work
// at a time, and the next item can be accepted from the cycle in which the result
// appears.
// Send a temperature reading before pressure so the stored term is current.
`default_nettype none
module barometric_sensor_compensation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bsc_pkg::RawWidth-1:0]      req_tdata,  // raw_reading
   input  wire logic                              req_tuser,  // op
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bsc_pkg::ValueWidth-1:0]         rsp_tdata,  // value
   output logic [1:0]                             rsp_tuser,  // status, kind
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [bsc_pkg::CsrIdxW-1:0]       csr_index,
   input  wire logic [bsc_pkg::CsrDataW-1:0]      csr_data
);

   bsc_pkg::cmd_type  cmd;
   bsc_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   bsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bsc_datapath u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [7:0] CsrNoReg = 8'd9;

   class press_temp_board;
      logic [63:0] word_a, word_b;
      logic [47:0] word_c;
      logic [1:0]  oss;
      logic [31:0] b5;
      logic [33:0] pending[$];
      int          errors;
      int          checked;

      function new();
         word_a = '0; word_b = '0; word_c = '0; oss = '0; b5 = '0;
         errors = 0; checked = 0;
      endfunction

      function void apply_csr(logic [7:0] idx, logic [63:0] val);
         if (idx == bsc_pkg::CSR_COEFF_A) word_a = val;
         else if (idx == bsc_pkg::CSR_COEFF_B) word_b = val;
         else if (idx == bsc_pkg::CSR_COEFF_C) word_c = val[47:0];
         else if (idx == bsc_pkg::CSR_OSS) oss = val[1:0];
      endfunction

      function logic [31:0] ext16(logic [15:0] v);
         return {{16{v[15]}}, v};
      endfunction

      function logic [31:0] sra(logic [31:0] v, int s);
         return 32'($signed(v) >>> s);
      endfunction

      // expected {kind, status, value}
      function void note_reading(logic op, logic [23:0] raw);
         logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
         logic [31:0] x1, x2, x3, den, an, ad, q, up, b6, sq, b3, b4, b7, p, h;
         logic [31:0] value;
         logic        status;
         value = '0; status = 1'b0;
         ac1 = ext16(word_a[63:48]); ac2 = ext16(word_a[47:32]);
         ac3 = ext16(word_a[31:16]); ac4 = {16'd0, word_a[15:0]};
         ac5 = {16'd0, word_b[63:48]}; ac6 = {16'd0, word_b[47:32]};
         b1 = ext16(word_b[31:16]); b2 = ext16(word_b[15:0]);
         mc = ext16(word_c[31:16]); md = ext16(word_c[15:0]);
         if (op == bsc_pkg::OP_TEMP) begin
            x1 = sra(({16'd0, raw[15:0]} - ac6) * ac5, 15);
            den = x1 + md;
            if (den == 0) begin
               status = 1'b1;
            end else begin
               x2 = mc << 11;
               an = x2[31] ? -x2 : x2;
               ad = den[31] ? -den : den;
               q = an / ad;
               if (x2[31] != den[31]) q = -q;
               b5 = x1 + q;
               value = sra(b5 + 32'd8, 4);
            end
         end else begin
            up = {8'd0, raw} >> (8 - oss);
            b6 = b5 - 32'd4000;
            sq = sra(b6 * b6, 12);
            x1 = sra(b2 * sq, 11);
            x2 = sra(ac2 * b6, 11);
            b3 = sra(((ac1 * 4 + x1 + x2) << oss) + 32'd2, 2);
            x1 = sra(ac3 * b6, 13);
            x2 = sra(b1 * sq, 16);
            x3 = sra(x1 + x2 + 32'd2, 2);
            b4 = (ac4 * (x3 + 32'd32768)) >> 15;
            b7 = (up - b3) * (32'd50000 >> oss);
            if (b4 == 0) begin
               status = 1'b1;
            end else begin
               if (!b7[31]) p = (b7 << 1) / b4;
               else p = (b7 / b4) << 1;
               h = sra(p, 8);
               x1 = sra(h * h * 32'd3038, 16);
               x2 = sra(32'hFFFF_E343 * p, 16);
               value = p + sra(x1 + x2 + 32'd3791, 4);
            end
         end
         pending.push_back({op, status, value});
      endfunction

      task check_result(logic kind, logic status, logic [31:0] value);
         logic [33:0] exp;
         checked++;
         if (pending.size() == 0) begin
            report_error("result with nothing pending");
            return;
         end
         exp = pending.pop_front();
         if (kind != exp[33]) report_error($sformatf("kind %0d want %0d", kind, exp[33]));
         if (status != exp[32])
            report_error($sformatf("status %0d want %0d", status, exp[32]));
         if (value != exp[31:0])
            report_error($sformatf("value %0h want %0h", value, exp[31:0]));
      endtask

      task report_error(string msg);
         errors++;
         $display("mismatch %0d: %s", errors, msg);
      endtask
   endclass

   logic        clock = 0, reset = 1;
   logic        req_tvalid = 0, req_tuser = 0;
   logic [23:0] req_tdata = '0;
   wire         req_tready, rsp_tvalid, csr_ready;
   logic        rsp_tready = 0;
   wire [31:0]  rsp_tdata;
   wire [1:0]   rsp_tuser;
   logic        csr_valid = 0;
   logic [7:0]  csr_index = '0;
   logic [63:0] csr_data = '0;
   int          cycles = 0;
   int          idle_pct = 38;
   int          nitems = 0;
   press_temp_board board = new();

   barometric_sensor_compensation u_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 1000000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_result(rsp_tuser[0], rsp_tuser[1], rsp_tdata);
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   task automatic write_csr(logic [7:0] idx, logic [63:0] val);
      csr_valid <= 1; csr_index <= idx; csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.apply_csr(idx, val);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic send_reading(logic op, logic [23:0] raw);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1; req_tuser <= op; req_tdata <= raw;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.note_reading(op, raw);
      nitems++;
   endtask

   task automatic drain();
      req_tvalid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic typical_coeffs(logic [1:0] o);
      write_csr(bsc_pkg::CSR_COEFF_A, {16'd408, -16'sd72, -16'sd14383, 16'd32741});
      write_csr(bsc_pkg::CSR_COEFF_B, {16'd32757, 16'd23153, 16'd6190, 16'd4});
      write_csr(bsc_pkg::CSR_COEFF_C, {-16'sd32768, -16'sd8711, 16'd2868});
      write_csr(bsc_pkg::CSR_OSS, {62'd0, o});
   endtask

   task automatic jitter_coeffs();
      write_csr(bsc_pkg::CSR_COEFF_A, {16'd408 + 16'($urandom_range(63)) - 16'd32,
                                       -16'sd72 + 16'($urandom_range(31)),
                                       -16'sd14383 + 16'($urandom_range(511)),
                                       16'd32741 - 16'($urandom_range(2000))});
      write_csr(bsc_pkg::CSR_COEFF_B, {16'd32757 - 16'($urandom_range(500)),
                                       16'd23153 + 16'($urandom_range(500)),
                                       16'd6190, 16'd4 + 16'($urandom_range(7))});
      write_csr(bsc_pkg::CSR_COEFF_C, {16'($urandom), -16'sd8711, 16'd2868});
      write_csr(bsc_pkg::CSR_OSS, {62'd0, 2'($urandom_range(3))});
   endtask

   initial begin
      int k;
      repeat (9) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: pressure before any temperature, zero divisors from reset
      send_reading(bsc_pkg::OP_PRESS, 24'h5d23c0);
      send_reading(bsc_pkg::OP_TEMP, 24'h006c50);
      drain();
      typical_coeffs(2'd0);
      drain();
      send_reading(bsc_pkg::OP_TEMP, 24'hff6c50);
      send_reading(bsc_pkg::OP_PRESS, 24'h5d23c0);
      send_reading(bsc_pkg::OP_TEMP, 24'h000000);
      send_reading(bsc_pkg::OP_TEMP, 24'hffffff);
      send_reading(bsc_pkg::OP_PRESS, 24'h000000);
      send_reading(bsc_pkg::OP_PRESS, 24'hffffff);
      drain();
      write_csr(bsc_pkg::CSR_OSS, 64'd3);
      send_reading(bsc_pkg::OP_TEMP, 24'h006c50);
      send_reading(bsc_pkg::OP_PRESS, 24'h5d23c0);
      send_reading(bsc_pkg::OP_PRESS, 24'hffffff);
      drain();
      // zero temperature divisor: x1 and md are both zero at ut == ac6
      write_csr(bsc_pkg::CSR_COEFF_C, 48'h0000_1234_0000);
      send_reading(bsc_pkg::OP_TEMP, 24'h005a71);
      send_reading(bsc_pkg::OP_PRESS, 24'h123456);
      drain();
      // extreme words, division overflow, zero b4
      write_csr(bsc_pkg::CSR_COEFF_A, '1);
      write_csr(bsc_pkg::CSR_COEFF_B, '1);
      write_csr(bsc_pkg::CSR_COEFF_C, '1);
      write_csr(CsrNoReg, '1);
      send_reading(bsc_pkg::OP_TEMP, 24'h00ffff);
      send_reading(bsc_pkg::OP_PRESS, 24'hffffff);
      drain();
      write_csr(bsc_pkg::CSR_COEFF_A, 64'h8000_8000_8000_0000);
      write_csr(bsc_pkg::CSR_COEFF_B, 64'hffff_0000_8000_8000);
      write_csr(bsc_pkg::CSR_COEFF_C, 48'h7fff_8000_0001);
      send_reading(bsc_pkg::OP_TEMP, 24'h000000);
      send_reading(bsc_pkg::OP_PRESS, 24'h800000);
      drain();
      write_csr(bsc_pkg::CSR_OSS, 64'hffff_ffff_ffff_fffc);
      send_reading(bsc_pkg::OP_PRESS, 24'h7fffff);
      drain();
      // random: realistic calibrations, some raw noise
      for (k = 0; k < 1700; k++) begin
         if (k % 100 == 0) begin
            drain();
            if (k % 500 == 250) begin
               write_csr(bsc_pkg::CSR_COEFF_A, {$urandom, $urandom});
               write_csr(bsc_pkg::CSR_COEFF_B, {$urandom, $urandom});
               write_csr(bsc_pkg::CSR_COEFF_C, {16'($urandom), $urandom});
               write_csr(bsc_pkg::CSR_OSS, 64'($urandom));
            end else begin
               jitter_coeffs();
            end
            idle_pct = (k >= 600 && k < 800) ? 0 : 38;
         end
         if ($urandom_range(9) < 4)
            send_reading(bsc_pkg::OP_TEMP, ($urandom_range(9) < 8) ?
                         24'(27000 + $urandom_range(4000)) : 24'($urandom));
         else
            send_reading(bsc_pkg::OP_PRESS, ($urandom_range(9) < 8) ?
                         24'h500000 + 24'($urandom_range(24'h1fffff)) : 24'($urandom));
      end
      drain();
      $display("sent %0d readings, checked %0d results over several calibrations",
               nitems, board.checked);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
`default_nettype wire
